// File: src/cau_pkg.sv
// shared constants and types of the complex arithmetic unit
`default_nettype none
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int KIND_WIDTH = 3;

   // operation codes; 5 to 7 mean no operation
   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_CMP = 3'd4
   } kind_type;

endpackage
`default_nettype wire

// File: src/cau_req_if.sv
// request channel: operation code and two complex operands
`default_nettype none
interface cau_req_if #(parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH);
   logic                          valid;
   logic                          ready;
   logic [cau_pkg::KIND_WIDTH-1:0] kind;
   logic signed [DATA_WIDTH-1:0]  a_re;
   logic signed [DATA_WIDTH-1:0]  a_im;
   logic signed [DATA_WIDTH-1:0]  b_re;
   logic signed [DATA_WIDTH-1:0]  b_im;

   modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface
`default_nettype wire

// File: src/cau_rsp_if.sv
// response channel: complex result and status flags
`default_nettype none
interface cau_rsp_if #(parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] res_re;
   logic signed [DATA_WIDTH-1:0] res_im;
   logic                         equal;
   logic                         overflow;
   logic                         div_zero;

   modport source (output valid, res_re, res_im, equal, overflow, div_zero, input ready);
   modport sink   (input valid, res_re, res_im, equal, overflow, div_zero, output ready);
endinterface
`default_nettype wire

// File: src/complex_arith_unit_core.sv
// Complex arithmetic unit: add, subtract, multiply, divide and compare on signed
// fixed-point complex operands. Fully pipelined: one beat is accepted per cycle
// while the output is not stalled, through DATA_WIDTH+5 register stages (input
// register, product stage, sum stage, divider setup, one stage per quotient bit
// of the restoring divider, output register). Every operation runs through the
// same pipe, so results keep request order. Each stage holds its beat until the
// next stage frees up, so bubbles are squeezed out under backpressure. Multiply
// rounds to nearest (ties away from zero), divide truncates toward zero, and both
// saturate with the overflow flag raised.
`default_nettype none
module complex_arith_unit_core #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   cau_req_if.sink   req_bus,
   cau_rsp_if.source rsp_bus
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;          // product
   localparam int SW = 2 * W + 1;      // product sum
   localparam int NW = SW + F;         // scaled dividend
   localparam int CW = NW + W + 1;     // divider compare width
   localparam int NS = W + 5;          // pipeline stages
   localparam int DS = 3;              // first divider stage

   localparam logic [W-1:0]  POS_MAX  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  NEG_CODE = {1'b1, {(W-1){1'b0}}};
   localparam logic [SW-1:0] POS_WIDE = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [SW-1:0] NEG_WIDE = {{(SW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [SW-1:0] HALF     = (SW'(1) << F) >> 1;

   typedef struct packed {
      cau_pkg::kind_type kind;
      logic [W-1:0]      re;
      logic [W-1:0]      im;
      logic              eq;
      logic              ovf;
      logic              dz;
   } carry_type;

   // saturate a W+1 bit sum, result {ovf, value}
   function automatic logic [W:0] sat_sum(input logic signed [W:0] v);
      logic [W:0] r;
      if (v > $signed({2'b00, {(W-1){1'b1}}})) begin
         r = {1'b1, POS_MAX};
      end else if (v < $signed({2'b11, {(W-1){1'b0}}})) begin
         r = {1'b1, NEG_CODE};
      end else begin
         r = {1'b0, v[W-1:0]};
      end
      return r;
   endfunction

   // saturate a sign-magnitude value, result {ovf, value}
   function automatic logic [W:0] sat_sm(input logic neg, input logic [SW-1:0] mag);
      logic [W:0] r;
      if (neg) begin
         if (mag > NEG_WIDE) begin
            r = {1'b1, NEG_CODE};
         end else begin
            r = {1'b0, W'(~mag + SW'(1))};
         end
      end else if (mag > POS_WIDE) begin
         r = {1'b1, POS_MAX};
      end else begin
         r = {1'b0, mag[W-1:0]};
      end
      return r;
   endfunction

   // stage enables and valid bits
   logic [NS-1:0] v_ff, v_in, en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_bus.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_bus.valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_bus.ready = en[0];

   // stage 0: input register
   cau_pkg::kind_type     s0_kind_ff;
   logic signed [W-1:0]   s0_are_ff, s0_aim_ff, s0_bre_ff, s0_bim_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_kind_ff <= cau_pkg::kind_type'(req_bus.kind);
         s0_are_ff  <= req_bus.a_re;
         s0_aim_ff  <= req_bus.a_im;
         s0_bre_ff  <= req_bus.b_re;
         s0_bim_ff  <= req_bus.b_im;
      end
   end

   // stage 1: products, add/sub/compare results
   logic signed [PW-1:0] s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_br2_ff, s1_bi2_ff;
   carry_type            s1_c_ff, s1_c_in;
   logic [W:0]           s1_sat_re, s1_sat_im;

   always_comb begin
      s1_c_in      = '0;
      s1_c_in.kind = s0_kind_ff;
      s1_sat_re    = '0;
      s1_sat_im    = '0;
      case (s0_kind_ff)
         cau_pkg::KIND_ADD, cau_pkg::KIND_SUB: begin
            if (s0_kind_ff == cau_pkg::KIND_ADD) begin
               s1_sat_re = sat_sum({s0_are_ff[W-1], s0_are_ff} + {s0_bre_ff[W-1], s0_bre_ff});
               s1_sat_im = sat_sum({s0_aim_ff[W-1], s0_aim_ff} + {s0_bim_ff[W-1], s0_bim_ff});
            end else begin
               s1_sat_re = sat_sum({s0_are_ff[W-1], s0_are_ff} - {s0_bre_ff[W-1], s0_bre_ff});
               s1_sat_im = sat_sum({s0_aim_ff[W-1], s0_aim_ff} - {s0_bim_ff[W-1], s0_bim_ff});
            end
            s1_c_in.re  = s1_sat_re[W-1:0];
            s1_c_in.im  = s1_sat_im[W-1:0];
            s1_c_in.ovf = s1_sat_re[W] | s1_sat_im[W];
         end
         cau_pkg::KIND_DIV: begin
            s1_c_in.dz = (s0_bre_ff == '0) && (s0_bim_ff == '0);
         end
         cau_pkg::KIND_CMP: begin
            s1_c_in.eq = (s0_are_ff == s0_bre_ff) && (s0_aim_ff == s0_bim_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_rr_ff  <= s0_are_ff * s0_bre_ff;
         s1_ii_ff  <= s0_aim_ff * s0_bim_ff;
         s1_ri_ff  <= s0_are_ff * s0_bim_ff;
         s1_ir_ff  <= s0_aim_ff * s0_bre_ff;
         s1_br2_ff <= s0_bre_ff * s0_bre_ff;
         s1_bi2_ff <= s0_bim_ff * s0_bim_ff;
         s1_c_ff   <= s1_c_in;
      end
   end

   // stage 2: product sums and divisor
   logic signed [SW-1:0] s2_vr_ff, s2_vi_ff, s2_vr_in, s2_vi_in;
   logic [SW-1:0]        s2_den_ff;
   carry_type            s2_c_ff;
   logic signed [SW-1:0] x_rr, x_ii, x_ri, x_ir;
   carry_type            s2_c_in_pass;

   assign s2_c_in_pass = s1_c_ff;

   always_comb begin
      x_rr = {s1_rr_ff[PW-1], s1_rr_ff};
      x_ii = {s1_ii_ff[PW-1], s1_ii_ff};
      x_ri = {s1_ri_ff[PW-1], s1_ri_ff};
      x_ir = {s1_ir_ff[PW-1], s1_ir_ff};
      if (s1_c_ff.kind == cau_pkg::KIND_DIV) begin
         s2_vr_in = x_rr + x_ii;
         s2_vi_in = x_ir - x_ri;
      end else begin
         s2_vr_in = x_rr - x_ii;
         s2_vi_in = x_ri + x_ir;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_vr_ff  <= s2_vr_in;
         s2_vi_ff  <= s2_vi_in;
         s2_den_ff <= SW'(s1_br2_ff) + SW'(s1_bi2_ff);
         s2_c_ff   <= s2_c_in_pass;
      end
   end

   // divider pipeline, index 0 is setup, index j holds j quotient bits
   logic [CW-1:0] d_rem_re_ff [W+1];
   logic [CW-1:0] d_rem_im_ff [W+1];
   logic [W-1:0]  d_q_re_ff   [W+1];
   logic [W-1:0]  d_q_im_ff   [W+1];
   logic [SW-1:0] d_den_ff    [W+1];
   logic          d_neg_re_ff [W+1];
   logic          d_neg_im_ff [W+1];
   logic          d_big_re_ff [W+1];
   logic          d_big_im_ff [W+1];
   carry_type     d_c_ff      [W+1];

   // setup: magnitudes, multiply rounding, dividend scaling
   logic          neg_re, neg_im;
   logic [SW-1:0] mag_re, mag_im;
   logic [CW-1:0] n_re, n_im, den_top;
   logic [W:0]    m_sat_re, m_sat_im;
   carry_type     d0_c_in;

   always_comb begin
      neg_re   = s2_vr_ff[SW-1];
      neg_im   = s2_vi_ff[SW-1];
      mag_re   = neg_re ? SW'(-s2_vr_ff) : SW'(s2_vr_ff);
      mag_im   = neg_im ? SW'(-s2_vi_ff) : SW'(s2_vi_ff);
      n_re     = CW'(mag_re) << F;
      n_im     = CW'(mag_im) << F;
      den_top  = CW'(s2_den_ff) << W;
      m_sat_re = sat_sm(neg_re, (mag_re + HALF) >> F);
      m_sat_im = sat_sm(neg_im, (mag_im + HALF) >> F);
      d0_c_in  = s2_c_ff;
      if (s2_c_ff.kind == cau_pkg::KIND_MUL) begin
         d0_c_in.re  = m_sat_re[W-1:0];
         d0_c_in.im  = m_sat_im[W-1:0];
         d0_c_in.ovf = m_sat_re[W] | m_sat_im[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[DS]) begin
         d_rem_re_ff[0] <= n_re;
         d_rem_im_ff[0] <= n_im;
         d_q_re_ff[0]   <= '0;
         d_q_im_ff[0]   <= '0;
         d_den_ff[0]    <= s2_den_ff;
         d_neg_re_ff[0] <= neg_re;
         d_neg_im_ff[0] <= neg_im;
         d_big_re_ff[0] <= n_re >= den_top;
         d_big_im_ff[0] <= n_im >= den_top;
         d_c_ff[0]      <= d0_c_in;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 1; j <= W; j++) begin : g_div
      logic [CW-1:0] trial;
      logic          take_re, take_im;

      always_comb begin
         trial   = CW'(d_den_ff[j-1]) << (W - j);
         take_re = d_rem_re_ff[j-1] >= trial;
         take_im = d_rem_im_ff[j-1] >= trial;
      end

      always_ff @(posedge clock) begin
         if (en[DS+j]) begin
            d_rem_re_ff[j] <= take_re ? d_rem_re_ff[j-1] - trial : d_rem_re_ff[j-1];
            d_rem_im_ff[j] <= take_im ? d_rem_im_ff[j-1] - trial : d_rem_im_ff[j-1];
            d_q_re_ff[j]   <= {d_q_re_ff[j-1][W-2:0], take_re};
            d_q_im_ff[j]   <= {d_q_im_ff[j-1][W-2:0], take_im};
            d_den_ff[j]    <= d_den_ff[j-1];
            d_neg_re_ff[j] <= d_neg_re_ff[j-1];
            d_neg_im_ff[j] <= d_neg_im_ff[j-1];
            d_big_re_ff[j] <= d_big_re_ff[j-1];
            d_big_im_ff[j] <= d_big_im_ff[j-1];
            d_c_ff[j]      <= d_c_ff[j-1];
         end
      end
   end

   // output stage: quotient saturation and result select
   carry_type out_ff, out_in;
   logic [W:0] q_sat_re, q_sat_im;

   always_comb begin
      q_sat_re = d_big_re_ff[W] ? {1'b1, (d_neg_re_ff[W] ? NEG_CODE : POS_MAX)}
                                : sat_sm(d_neg_re_ff[W], SW'(d_q_re_ff[W]));
      q_sat_im = d_big_im_ff[W] ? {1'b1, (d_neg_im_ff[W] ? NEG_CODE : POS_MAX)}
                                : sat_sm(d_neg_im_ff[W], SW'(d_q_im_ff[W]));
      out_in = d_c_ff[W];
      if (d_c_ff[W].kind == cau_pkg::KIND_DIV && !d_c_ff[W].dz) begin
         out_in.re  = q_sat_re[W-1:0];
         out_in.im  = q_sat_im[W-1:0];
         out_in.ovf = q_sat_re[W] | q_sat_im[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid    = v_ff[NS-1];
   assign rsp_bus.res_re   = out_ff.re;
   assign rsp_bus.res_im   = out_ff.im;
   assign rsp_bus.equal    = out_ff.eq;
   assign rsp_bus.overflow = out_ff.ovf;
   assign rsp_bus.div_zero = out_ff.dz;

   // divide by zero gives a clean zero result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.div_zero |->
         rsp_bus.res_re == '0 && rsp_bus.res_im == '0 && !rsp_bus.overflow && !rsp_bus.equal)
      else $error("div_zero beat with nonzero result or flags");

   // a compare never reports overflow or a value
   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.equal |->
         rsp_bus.res_re == '0 && rsp_bus.res_im == '0 && !rsp_bus.overflow)
      else $error("equal beat with nonzero result");

   // an accepted beat moves into the product stage when it is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && en[1] |=> v_ff[1])
      else $error("beat lost between input and product stage");

   // the output stage holds its beat while the sink stalls
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && !rsp_bus.ready |=> v_ff[NS-1] && $stable(out_ff))
      else $error("output beat dropped or changed under stall");

endmodule
`default_nettype wire

// File: tb/complex_arith_unit_core_tb.sv
// testbench of the complex arithmetic unit: random and directed beats against a predictor
`default_nettype none
module complex_arith_unit_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam int FB = cau_pkg::FRAC_BITS;
   localparam int KW = cau_pkg::KIND_WIDTH;
   localparam int LATENCY = DW + 4;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic                 equal;
      logic                 overflow;
      logic                 div_zero;
   } cplx_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   cau_req_if req_bus ();
   cau_rsp_if rsp_bus ();

   complex_arith_unit_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   cplx_result_type expected_results[$];
   int     mismatch_count = 0;
   int     result_count = 0;
   int     item_count = 0;
   longint cycle_count = 0;
   bit     hold_off_long = 1'b0;
   bit     sink_stall_on = 1'b1;

   // saturate an exact value to the component range
   function automatic logic [DW-1:0] clamp_component(input longint v, inout logic ovf);
      longint hi, lo;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      lo = -(longint'(1) <<< (DW - 1));
      if (v > hi) begin
         ovf = 1'b1;
         return hi[DW-1:0];
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // round to nearest, ties away from zero
   function automatic longint round_product(input longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (FB > 0) ? ((m + (longint'(1) <<< (FB - 1))) >>> FB) : m;
      return (v < 0) ? -m : m;
   endfunction

   // quotient with FB fraction bits, truncated toward zero
   function automatic longint divide_frac(input longint num, input longint den);
      longint m, q;
      m = (num < 0) ? -num : num;
      q = (m <<< FB) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic cplx_result_type predict_complex(input logic [KW-1:0] kind,
         input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
         input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
      cplx_result_type r;
      longint xr, xi, yr, yi, den;
      logic ovf;
      r = '0;
      ovf = 1'b0;
      xr = ar; xi = ai; yr = br; yi = bi;
      case (kind)
         cau_pkg::KIND_ADD: begin
            r.re = clamp_component(xr + yr, ovf);
            r.im = clamp_component(xi + yi, ovf);
         end
         cau_pkg::KIND_SUB: begin
            r.re = clamp_component(xr - yr, ovf);
            r.im = clamp_component(xi - yi, ovf);
         end
         cau_pkg::KIND_MUL: begin
            r.re = clamp_component(round_product(xr * yr - xi * yi), ovf);
            r.im = clamp_component(round_product(xr * yi + xi * yr), ovf);
         end
         cau_pkg::KIND_DIV: begin
            if (yr == 0 && yi == 0) r.div_zero = 1'b1;
            else begin
               den = yr * yr + yi * yi;
               r.re = clamp_component(divide_frac(xr * yr + xi * yi, den), ovf);
               r.im = clamp_component(divide_frac(xi * yr - xr * yi, den), ovf);
            end
         end
         cau_pkg::KIND_CMP: r.equal = (ar == br) && (ai == bi);
         default: ;
      endcase
      r.overflow = ovf;
      return r;
   endfunction

   // send one request beat after a random gap; valid stays up for a following beat
   task automatic send_op(input logic [KW-1:0] kind, input logic [DW-1:0] ar,
         input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi,
         input bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.a_re  <= ar;
      req_bus.a_im  <= ai;
      req_bus.b_re  <= br;
      req_bus.b_im  <= bi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(predict_complex(kind, ar, ai, br, bi));
      item_count++;
   endtask

   function automatic logic [DW-1:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(DW-1){1'b1}}};
         1: return {1'b1, {(DW-1){1'b0}}};
         2: return DW'($urandom_range(0, 3)) - DW'(1);
         3: return DW'($signed($urandom_range(0, 2047)) - 1024);
         default: return DW'($urandom);
      endcase
   endfunction

   // drop valid and wait for every expected result
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [DW-1:0] mx, mn, one;
      mx = {1'b0, {(DW-1){1'b1}}};
      mn = {1'b1, {(DW-1){1'b0}}};
      one = DW'(1) << FB;
      send_op(cau_pkg::KIND_ADD, mx, mn, mx, mn);
      send_op(cau_pkg::KIND_ADD, one, one, one, mn);
      send_op(cau_pkg::KIND_SUB, mn, mx, mx, mn);
      send_op(cau_pkg::KIND_SUB, '0, '0, mn, mn);
      send_op(cau_pkg::KIND_MUL, one, one, one, one);
      send_op(cau_pkg::KIND_MUL, mn, mn, mn, mn);
      send_op(cau_pkg::KIND_MUL, mx, mx, mx, mn);
      send_op(cau_pkg::KIND_MUL, DW'(1), '0, DW'(128), '0);
      send_op(cau_pkg::KIND_MUL, DW'(-1), '0, DW'(128), '0);
      send_op(cau_pkg::KIND_DIV, one, one, '0, '0);
      send_op(cau_pkg::KIND_DIV, mx, mn, DW'(1), '0);
      send_op(cau_pkg::KIND_DIV, one, '0, one, one);
      send_op(cau_pkg::KIND_DIV, mn, mn, mn, mn);
      send_op(cau_pkg::KIND_DIV, DW'(-3), DW'(5), DW'(7), DW'(-2));
      send_op(cau_pkg::KIND_CMP, mx, mn, mx, mn);
      send_op(cau_pkg::KIND_CMP, mx, mn, mx, mx);
      send_op(cau_pkg::KIND_CMP, '0, '0, '0, '0);
      send_op(3'd5, mx, mx, mx, mx);
      send_op(3'd6, one, one, one, one);
      send_op(3'd7, mn, mn, mn, mn);
   endtask

   task automatic test_random(input int count);
      logic [DW-1:0] ar, ai;
      for (int i = 0; i < count; i++) begin
         ar = rand_operand();
         ai = rand_operand();
         if ($urandom_range(0, 9) == 0)
            send_op(cau_pkg::KIND_CMP, ar, ai,
                    ($urandom_range(0, 1) ? ar : rand_operand()), ai);
         else if ($urandom_range(0, 15) == 0)
            send_op(cau_pkg::KIND_DIV, ar, ai, '0, '0);
         else
            send_op(3'($urandom_range(0, 7)), ar, ai, rand_operand(), rand_operand());
      end
   endtask

   // long sink hold-off while the source keeps pushing beats
   task automatic test_backpressure();
      hold_off_long = 1'b1;
      for (int i = 0; i < 3 * LATENCY; i++)
         send_op(3'($urandom_range(0, 4)), rand_operand(), rand_operand(),
                 rand_operand(), rand_operand(), 1'b1);
      hold_off_long = 1'b0;
      wait_drained();
   endtask

   // back-to-back beats with no stalls on either side
   task automatic test_full_rate();
      sink_stall_on = 1'b0;
      for (int i = 0; i < 60; i++)
         send_op(3'($urandom_range(0, 4)), rand_operand(), rand_operand(),
                 rand_operand(), rand_operand(), 1'b1);
      wait_drained();
      sink_stall_on = 1'b1;
   endtask

   // sink ready: random stalls, plus a long hold-off counted in cycles
   always @(posedge clock) begin
      int stall;
      if (reset) rsp_bus.ready <= 1'b0;
      else if (hold_off_long) begin
         rsp_bus.ready <= 1'b0;
         for (int c = 0; c < 8 * LATENCY; c++) @(posedge clock);
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end else begin
         stall = sink_stall_on && $urandom_range(0, 2) == 0 ? $urandom_range(1, 10) : 0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      cplx_result_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.res_re, rsp_bus.res_im, rsp_bus.equal, rsp_bus.overflow,
                rsp_bus.div_zero};
         result_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("result beat with nothing expected: %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch on result %0d: expected %p, got %p",
                           result_count, want, got);
            end
         end
      end
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** complex_arith_unit_core: FAILED **");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind  = '0;
      req_bus.a_re  = '0;
      req_bus.a_im  = '0;
      req_bus.b_re  = '0;
      req_bus.b_im  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250);
      wait_drained();
      test_backpressure();
      test_full_rate();
      test_random(280);
      wait_drained();
      repeat (2 * LATENCY) @(posedge clock);
      $display("sent %0d beats (all ops, unused codes, saturation, divide by zero),", item_count);
      $display("checked %0d results under random and long sink stalls", result_count);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("** complex_arith_unit_core: PASSED **");
      else
         $display("** complex_arith_unit_core: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
